// ===== sv/vfo_pkg.sv =====
// shared constants, codes and command/status types of the voxel face occlusion block
// no dependencies
package vfo_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int COORD_W     = 4;
    localparam int SIZE_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int FACE_W      = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam int FACE_XP = 0;
    localparam int FACE_XN = 1;
    localparam int FACE_YP = 2;
    localparam int FACE_YN = 3;
    localparam int FACE_ZP = 4;
    localparam int FACE_ZN = 5;

    typedef struct packed {
        logic load_item;
        logic clr_step;
        logic rd_first;
        logic rd_second;
        logic rd_third;
        logic wr_item;
        logic fin;
    } vfo_cmd_t;

    typedef struct packed {
        logic is_query;
        logic in_chunk;
        logic out_free;
        logic clr_last;
    } vfo_stat_t;

endpackage

// ===== sv/voxel_face_occlusion.sv =====
// voxel face occlusion top level: a query item runs three rounds of row reads on the two
// read ports of the map; a write item reads its row and writes it back; out-of-range
// writes are dropped and out-of-range queries skip the reads. after reset the map is
// cleared to opaque, one row a cycle over all MAX_DIM*MAX_DIM rows, with s_tready low;
// sizes reset to 16; depends on vfo_pkg, vfo_ctrl, vfo_datapath
module voxel_face_occlusion #(
    parameter int MAX_DIM = vfo_pkg::MAX_DIM_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [vfo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vfo_pkg::SIZE_W-1:0]       cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // coord_x, coord_y, coord_z, is_transparent, zero fill
    input  logic [vfo_pkg::IN_TDATA_W-1:0]   s_tdata,
    // operation
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // face_mask, zero fill
    output logic [vfo_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // out_of_range
    output logic                             m_tuser
);
    import vfo_pkg::*;

    vfo_cmd_t  cmd;
    vfo_stat_t stat;

    vfo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vfo_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== sv/vfo_ctrl.sv =====
// controller state machine: clearing pass, item sequencing over the row memory reads
// depends on vfo_pkg
module vfo_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  vfo_pkg::vfo_stat_t stat,
    output vfo_pkg::vfo_cmd_t  cmd
);
    import vfo_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD0   = 3'd2;
    localparam logic [2:0] S_RD1   = 3'd3;
    localparam logic [2:0] S_RD2   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;

    logic [2:0] st_reg;
    logic [2:0] st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_CLEAR;
        end else begin
            st_reg <= st_next;
        end
    end

    always_comb begin
        st_next  = st_reg;
        cmd      = '0;
        s_tready = 1'b0;
        case (st_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    st_next       = S_RD0;
                end
            end
            S_RD0: begin
                if (!stat.in_chunk) begin
                    st_next = stat.is_query ? S_FIN : S_IDLE;
                end else begin
                    cmd.rd_first = 1'b1;
                    st_next      = stat.is_query ? S_RD1 : S_WR;
                end
            end
            S_RD1: begin
                cmd.rd_second = 1'b1;
                st_next       = S_RD2;
            end
            S_RD2: begin
                cmd.rd_third = 1'b1;
                st_next      = S_FIN;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.fin = 1'b1;
                    st_next = S_IDLE;
                end
            end
            S_WR: begin
                cmd.wr_item = 1'b1;
                st_next     = S_IDLE;
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/vfo_datapath.sv =====
// datapath: size registers, item registers, row memory of the transparency map,
// neighbor checks, face mask assembly and output register; depends on vfo_pkg
module vfo_datapath #(
    parameter int MAX_DIM = vfo_pkg::MAX_DIM_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [vfo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vfo_pkg::SIZE_W-1:0]       cfg_data,
    input  logic [vfo_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    input  vfo_pkg::vfo_cmd_t                cmd,
    output vfo_pkg::vfo_stat_t               stat,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [vfo_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tuser
);
    import vfo_pkg::*;

    localparam int AW    = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int RAW   = $clog2(DEPTH);
    localparam int RW1   = RAW + 1;
    localparam int EW    = $clog2(MAX_DIM + 1);
    localparam int CMPW  = ((EW > SIZE_W) ? EW : SIZE_W) + 1;

    function automatic logic [CMPW-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [CMPW-1:0] ext;
        ext = CMPW'(s);
        return (ext > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : ext;
    endfunction

    function automatic logic [RAW-1:0] row_addr(input logic [CMPW-1:0] x,
                                                 input logic [CMPW-1:0] y);
        logic [RW1-1:0] t;
        t = RW1'(x) * RW1'(MAX_DIM) + RW1'(y);
        return t[RAW-1:0];
    endfunction

    logic [SIZE_W-1:0]  size_x_reg, size_y_reg, size_z_reg;
    logic               op_reg, tr_reg;
    logic [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [RAW-1:0]     clr_cnt_reg;
    logic [MAX_DIM-1:0] mem [DEPTH];
    logic [MAX_DIM-1:0] rd_a_reg, rd_b_reg;
    logic [FACE_W-1:0]  vis_reg;
    logic               m_tvalid_reg;
    logic [FACE_W-1:0]  mask_reg;
    logic               oor_reg;

    logic [CMPW-1:0]    ex, ey, ez, cx_w, cy_w, cz_w;
    logic [CMPW-1:0]    xp_w, xn_w, yp_w, yn_w, zp_w, zn_w;
    logic               in_chunk, xp_ok, xn_ok, yp_ok, yn_ok, zp_ok, zn_ok;
    logic [AW-1:0]      zi, zpi, zni;
    logic [RAW-1:0]     center_addr, addr_a, addr_b, mem_waddr;
    logic               rd_a_en, rd_b_en, mem_we;
    logic [MAX_DIM-1:0] row_wr, mem_wdata;
    logic               yn_vis;
    logic [FACE_W-1:0]  mask_next;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data;
                REG_SIZE_Y: size_y_reg <= cfg_data;
                REG_SIZE_Z: size_z_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg <= s_tuser;
            cx_reg <= s_tdata[3:0];
            cy_reg <= s_tdata[7:4];
            cz_reg <= s_tdata[11:8];
            tr_reg <= s_tdata[12];
        end
    end

    // bounds and neighbor checks
    always_comb begin
        ex       = eff_size(size_x_reg);
        ey       = eff_size(size_y_reg);
        ez       = eff_size(size_z_reg);
        cx_w     = CMPW'(cx_reg);
        cy_w     = CMPW'(cy_reg);
        cz_w     = CMPW'(cz_reg);
        xp_w     = cx_w + CMPW'(1);
        xn_w     = cx_w - CMPW'(1);
        yp_w     = cy_w + CMPW'(1);
        yn_w     = cy_w - CMPW'(1);
        zp_w     = cz_w + CMPW'(1);
        zn_w     = cz_w - CMPW'(1);
        in_chunk = (cx_w < ex) && (cy_w < ey) && (cz_w < ez);
        xp_ok    = xp_w < ex;
        xn_ok    = cx_reg != '0;
        yp_ok    = yp_w < ey;
        yn_ok    = cy_reg != '0;
        zp_ok    = zp_w < ez;
        zn_ok    = cz_reg != '0;
        zi       = cz_w[AW-1:0];
        zpi      = zp_w[AW-1:0];
        zni      = zn_w[AW-1:0];
    end

    // memory addressing
    always_comb begin
        center_addr = row_addr(cx_w, cy_w);
        addr_a      = center_addr;
        addr_b      = '0;
        if (cmd.rd_first) begin
            addr_b = xp_ok ? row_addr(xp_w, cy_w) : '0;
        end else if (cmd.rd_second) begin
            addr_a = xn_ok ? row_addr(xn_w, cy_w) : '0;
            addr_b = yp_ok ? row_addr(cx_w, yp_w) : '0;
        end else if (cmd.rd_third) begin
            addr_a = yn_ok ? row_addr(cx_w, yn_w) : '0;
        end
        rd_a_en = cmd.rd_first || cmd.rd_second || cmd.rd_third;
        rd_b_en = cmd.rd_first || cmd.rd_second;

        row_wr     = rd_a_reg;
        row_wr[zi] = tr_reg;

        mem_we    = cmd.clr_step || cmd.wr_item;
        mem_waddr = cmd.clr_step ? clr_cnt_reg : center_addr;
        mem_wdata = cmd.clr_step ? '0 : row_wr;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_a_en) begin
            rd_a_reg <= mem[addr_a];
        end
        if (rd_b_en) begin
            rd_b_reg <= mem[addr_b];
        end
    end

    // clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + RAW'(1);
        end
    end

    // visible faces collected as row reads return
    always_ff @(posedge aclk) begin
        if (cmd.rd_second) begin
            vis_reg[FACE_XP] <= !xp_ok || rd_b_reg[zi];
            vis_reg[FACE_ZP] <= !zp_ok || rd_a_reg[zpi];
            vis_reg[FACE_ZN] <= !zn_ok || rd_a_reg[zni];
        end
        if (cmd.rd_third) begin
            vis_reg[FACE_XN] <= !xn_ok || rd_a_reg[zi];
            vis_reg[FACE_YP] <= !yp_ok || rd_b_reg[zi];
            vis_reg[FACE_YN] <= 1'b1;
        end
    end

    always_comb begin
        yn_vis             = !yn_ok || rd_a_reg[zi];
        mask_next          = vis_reg;
        mask_next[FACE_YN] = yn_vis;
        if (!in_chunk) begin
            mask_next = '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.fin) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            mask_reg <= mask_next;
            oor_reg  <= !in_chunk;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = {{(OUT_TDATA_W - FACE_W){1'b0}}, mask_reg};
    assign m_tuser       = oor_reg;
    assign stat.is_query = op_reg == OP_QUERY;
    assign stat.in_chunk = in_chunk;
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign stat.clr_last = clr_cnt_reg == RAW'(DEPTH - 1);

endmodule
